// File: design/assert_macros.svh
// Assertion macros shared by the sector map RTL.
// Defining NO_ASSERTIONS leaves every use empty.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RHSM_ASSERT_NOW(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");
`define RHSM_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("%m: check failed");
`else
`define RHSM_ASSERT_NOW(label, clk, rst_n, prop)
`define RHSM_ASSERT_NEXT(label, clk, rst_n, cond, conseq)
`endif
`endif

// File: design/rhsm_pkg.sv
// Types and constants of the region header sector map.
// No dependencies; used by rhsm_run_unit, the top level and the testbench.
`timescale 1ns / 1ps

package rhsm_pkg;

  localparam int WORD_BITS = 64;
  localparam int WORD_SH   = 6;
  localparam int POS_W     = 25;
  localparam int ROWF_W    = POS_W - WORD_SH;
  localparam int TOTAL_W   = 15;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_WIPE,
    ST_IDLE,
    ST_CHECK,
    ST_RD,
    ST_WR,
    ST_QRD,
    ST_QDAT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    kind_t        kind;
    logic [31:0]  location_word;
    logic [31:0]  time_word;
    logic [13:0]  sector_index;
  } in_t;

  typedef struct packed {
    logic [9:0]   entry_index;
    logic [23:0]  chunk_offset;
    logic [7:0]   chunk_sectors;
    logic [31:0]  chunk_time;
    logic         out_of_range;
    logic         sector_free;
  } out_t;

  typedef struct packed {
    logic [ROWF_W-1:0]    row;
    logic [WORD_BITS-1:0] mask;
    logic [POS_W-1:0]     next;
    logic                 last;
  } run_step_t;

endpackage

// File: design/rhsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rhsm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/rhsm_run_unit.sv
// Shared run stepper: mask of one bitmap word covered by a sector run, and the next position.
// Depends on rhsm_pkg.
`timescale 1ns / 1ps

module rhsm_run_unit (
  input  logic [rhsm_pkg::POS_W-1:0] cur_i,
  input  logic [rhsm_pkg::POS_W-1:0] end_i,
  output rhsm_pkg::run_step_t        step_o
);

  localparam int WB = rhsm_pkg::WORD_BITS;
  localparam int SH = rhsm_pkg::WORD_SH;
  localparam int PW = rhsm_pkg::POS_W;
  localparam int RW = rhsm_pkg::ROWF_W;

  logic [RW-1:0] row_cur;
  logic [RW-1:0] row_end;
  logic          same_row;
  logic [WB-1:0] lo_mask;
  logic [WB-1:0] hi_mask;
  logic [PW-1:0] next_pos;

  always_comb begin
    row_cur  = cur_i[PW-1:SH];
    row_end  = end_i[PW-1:SH];
    same_row = (row_cur == row_end);
    lo_mask  = {WB{1'b1}} << cur_i[SH-1:0];
    hi_mask  = same_row ? ~({WB{1'b1}} << end_i[SH-1:0]) : {WB{1'b1}};
    next_pos = same_row ? end_i : {row_cur + RW'(1), {SH{1'b0}}};
    step_o.row  = row_cur;
    step_o.mask = lo_mask & hi_mask;
    step_o.next = next_pos;
    step_o.last = (next_pos == end_i);
  end

endmodule

// File: design/region_header_sector_map_top.sv
// Top level of the region header sector map: sequencer, entry counter and bitmap RAM.
// Depends on rhsm_pkg, rhsm_ram, rhsm_run_unit and assert_macros.svh.
//
//  channel | direction | payload            | handshake
//  in_     | input     | rhsm_pkg::in_t     | in_valid / in_ready
//  out_    | output    | rhsm_pkg::out_t    | out_valid / out_ready
//  cfg_    | input     | 15-bit sector total | cfg_valid / cfg_ready
//
// A header entry is checked, then each 64-bit bitmap word its run touches is read and then
// written; a rejected or empty entry skips the bitmap, a query reads one word (none when the
// sector lies beyond the total), and kind 3 goes straight to its result.
// A begin request rewrites every bitmap word, one per cycle.
// After reset the same pass runs before in_ready rises.
// A stalled result holds the block only once the next result is ready to leave.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module region_header_sector_map_top #(
  parameter int MAX_SECTORS = 16384,
  parameter int ENTRIES     = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rhsm_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rhsm_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rhsm_pkg::TOTAL_W-1:0]    cfg_data
);

  localparam int WB    = rhsm_pkg::WORD_BITS;
  localparam int SH    = rhsm_pkg::WORD_SH;
  localparam int PW    = rhsm_pkg::POS_W;
  localparam int ROWS  = (MAX_SECTORS + WB - 1) / WB;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  rhsm_pkg::state_t            state_r, state_nxt;
  rhsm_pkg::in_t               item_r, item_nxt;
  rhsm_pkg::out_t              res_r, res_nxt;
  rhsm_pkg::out_t              out_data_r;
  logic                        out_valid_r;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [PW-1:0]               cur_r, cur_nxt;
  logic [PW-1:0]               end_r, end_nxt;
  logic [ROW_W-1:0]            clr_row_r, clr_row_nxt;
  logic [rhsm_pkg::TOTAL_W-1:0] total_r;

  logic [PW-1:0]               eff_total;
  logic [PW-1:0]               in_end;
  logic [PW-1:0]               q_pos;
  logic                        clr_last;
  logic                        emit_go;
  rhsm_pkg::run_step_t         step;

  logic                        ram_we;
  logic [ROW_W-1:0]            ram_waddr;
  logic [WB-1:0]               ram_wdata;
  logic                        ram_re;
  logic [ROW_W-1:0]            ram_raddr;
  logic [WB-1:0]               ram_rdata;

  rhsm_run_unit u_run (
    .cur_i  (cur_r),
    .end_i  (end_r),
    .step_o (step)
  );

  rhsm_ram #(
    .WIDTH (WB),
    .DEPTH (ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    eff_total = ({{(PW - rhsm_pkg::TOTAL_W){1'b0}}, total_r} > PW'(MAX_SECTORS)) ?
                PW'(MAX_SECTORS) : {{(PW - rhsm_pkg::TOTAL_W){1'b0}}, total_r};
    in_end    = {1'b0, in_data.location_word[31:8]} + PW'(in_data.location_word[7:0]);
    q_pos     = PW'(item_r.sector_index);
    clr_last  = (clr_row_r == ROW_W'(ROWS - 1));
    emit_go   = !out_valid_r || out_ready;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rhsm_pkg::ST_INIT: begin
        if (clr_last) begin
          state_nxt = rhsm_pkg::ST_IDLE;
        end
      end
      rhsm_pkg::ST_WIPE: begin
        if (clr_last) begin
          state_nxt = rhsm_pkg::ST_EMIT;
        end
      end
      rhsm_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_data.kind)
            rhsm_pkg::KIND_BEGIN: state_nxt = rhsm_pkg::ST_WIPE;
            rhsm_pkg::KIND_ENTRY: state_nxt = rhsm_pkg::ST_CHECK;
            rhsm_pkg::KIND_QUERY: begin
              state_nxt = (PW'(in_data.sector_index) < eff_total) ?
                          rhsm_pkg::ST_QRD : rhsm_pkg::ST_EMIT;
            end
            default: state_nxt = rhsm_pkg::ST_EMIT;
          endcase
        end
      end
      rhsm_pkg::ST_CHECK: begin
        if ((end_r > eff_total) || (item_r.location_word[7:0] == 8'd0)) begin
          state_nxt = rhsm_pkg::ST_EMIT;
        end else begin
          state_nxt = rhsm_pkg::ST_RD;
        end
      end
      rhsm_pkg::ST_RD:   state_nxt = rhsm_pkg::ST_WR;
      rhsm_pkg::ST_WR:   state_nxt = step.last ? rhsm_pkg::ST_EMIT : rhsm_pkg::ST_RD;
      rhsm_pkg::ST_QRD:  state_nxt = rhsm_pkg::ST_QDAT;
      rhsm_pkg::ST_QDAT: state_nxt = rhsm_pkg::ST_EMIT;
      rhsm_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_nxt = rhsm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rhsm_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == rhsm_pkg::ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = clr_row_r;
    ram_wdata = (clr_row_r == '0) ? ~WB'(3) : {WB{1'b1}};
    ram_re    = 1'b0;
    ram_raddr = step.row[ROW_W-1:0];
    case (state_r)
      rhsm_pkg::ST_INIT, rhsm_pkg::ST_WIPE: begin
        ram_we = 1'b1;
      end
      rhsm_pkg::ST_RD: begin
        ram_re = 1'b1;
      end
      rhsm_pkg::ST_WR: begin
        ram_we    = 1'b1;
        ram_waddr = step.row[ROW_W-1:0];
        ram_wdata = ram_rdata & ~step.mask;
      end
      rhsm_pkg::ST_QRD: begin
        ram_re    = 1'b1;
        ram_raddr = q_pos[ROW_W+SH-1:SH];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    item_nxt    = item_r;
    res_nxt     = res_r;
    cnt_nxt     = cnt_r;
    cur_nxt     = cur_r;
    end_nxt     = end_r;
    clr_row_nxt = clr_row_r;
    case (state_r)
      rhsm_pkg::ST_INIT, rhsm_pkg::ST_WIPE: begin
        clr_row_nxt = clr_row_r + ROW_W'(1);
      end
      rhsm_pkg::ST_IDLE: begin
        if (in_valid) begin
          item_nxt            = in_data;
          res_nxt             = '0;
          res_nxt.entry_index = 10'(cnt_r);
          cur_nxt             = {1'b0, in_data.location_word[31:8]};
          end_nxt             = in_end;
          clr_row_nxt         = '0;
          case (in_data.kind)
            rhsm_pkg::KIND_BEGIN: begin
              res_nxt.entry_index = '0;
              cnt_nxt             = '0;
            end
            rhsm_pkg::KIND_ENTRY: begin
              cnt_nxt = (cnt_r == CNT_W'(ENTRIES - 1)) ? '0 : cnt_r + CNT_W'(1);
            end
            default: begin
            end
          endcase
        end
      end
      rhsm_pkg::ST_CHECK: begin
        if (end_r > eff_total) begin
          res_nxt.out_of_range = 1'b1;
        end else begin
          res_nxt.chunk_offset  = item_r.location_word[31:8];
          res_nxt.chunk_sectors = item_r.location_word[7:0];
          res_nxt.chunk_time    = item_r.time_word;
        end
      end
      rhsm_pkg::ST_WR: begin
        cur_nxt = step.next;
      end
      rhsm_pkg::ST_QDAT: begin
        res_nxt.sector_free = ram_rdata[q_pos[SH-1:0]];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rhsm_pkg::ST_INIT;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      clr_row_r   <= '0;
      total_r     <= rhsm_pkg::TOTAL_W'(2);
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      clr_row_r <= clr_row_nxt;
      if (cfg_valid) begin
        total_r <= cfg_data;
      end
      if (state_r == rhsm_pkg::ST_EMIT && emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    cur_r  <= cur_nxt;
    end_r  <= end_nxt;
    if (state_r == rhsm_pkg::ST_EMIT && emit_go) begin
      out_data_r <= res_r;
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RHSM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `RHSM_ASSERT_NEXT(a_read_then_write, clk, rst_n, state_r == rhsm_pkg::ST_RD, state_r == rhsm_pkg::ST_WR)
  `RHSM_ASSERT_NOW(a_write_inside_run, clk, rst_n, (state_r == rhsm_pkg::ST_WR) |-> (cur_r < end_r))
  `RHSM_ASSERT_NOW(a_single_port_use, clk, rst_n, !(ram_we && ram_re))

endmodule

// File: bench/region_header_sector_map_top_tb.sv
// Testbench of region_header_sector_map_top: directed and random requests checked against
// a bitmap predictor kept in a small scoreboard class. Depends on rhsm_pkg and the top level.
`timescale 1ns / 1ps

module region_header_sector_map_top_tb;

  localparam int          MAP_SECTORS   = 16384;
  localparam int          ENTRY_LIMIT   = 1024;
  localparam int          STALL_LIMIT   = 4000;
  localparam int          SETTLE_CYCLES = 20;
  localparam int          PHASE_ITEMS   = 100;
  localparam int          TAIL_ITEMS    = 150;
  localparam int unsigned PHASE_TOTALS [6] = '{16384, 700, 32767, 2, 5000, 16384};

  class sector_map_scoreboard;
    bit                 sector_free_bits [MAP_SECTORS];
    bit [9:0]           entry_count;
    bit [14:0]          sector_total;
    rhsm_pkg::out_t     expected_q [$];
    int unsigned        errors;
    int unsigned        results_seen;

    function new();
      wipe_bitmap();
      sector_total = 15'd2;
      errors = 0;
      results_seen = 0;
    endfunction

    function void wipe_bitmap();
      foreach (sector_free_bits[i]) sector_free_bits[i] = 1'b1;
      sector_free_bits[0] = 1'b0;
      sector_free_bits[1] = 1'b0;
      entry_count = '0;
    endfunction

    function void set_total(bit [14:0] value);
      sector_total = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_request(rhsm_pkg::in_t req);
      rhsm_pkg::out_t want;
      int unsigned    lim;
      int unsigned    first;
      int unsigned    stop;
      lim = (32'(sector_total) > MAP_SECTORS) ? MAP_SECTORS : 32'(sector_total);
      want = '0;
      want.entry_index = entry_count;
      case (req.kind)
        rhsm_pkg::KIND_BEGIN: begin
          wipe_bitmap();
          want.entry_index = '0;
        end
        rhsm_pkg::KIND_ENTRY: begin
          first = 32'(req.location_word[31:8]);
          stop = first + 32'(req.location_word[7:0]);
          if (stop > lim) begin
            want.out_of_range = 1'b1;
          end else begin
            for (int unsigned s = first; s < stop; s++) sector_free_bits[s] = 1'b0;
            want.chunk_offset = req.location_word[31:8];
            want.chunk_sectors = req.location_word[7:0];
            want.chunk_time = req.time_word;
          end
          entry_count = 10'((int'(entry_count) + 1) % ENTRY_LIMIT);
        end
        rhsm_pkg::KIND_QUERY: begin
          if (32'(req.sector_index) < lim) want.sector_free = sector_free_bits[req.sector_index];
        end
        default: begin
        end
      endcase
      expected_q.push_back(want);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (errors < 100) begin
        $display("MISMATCH result %0d %s: got %0h, expected %0h", results_seen, what, got, want);
      end
      errors++;
    endtask

    task check_result(rhsm_pkg::out_t got);
      rhsm_pkg::out_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", got[63:0], 64'd0);
        return;
      end
      want = expected_q.pop_front();
      if (got.entry_index !== want.entry_index)
        report_mismatch("entry_index", 64'(got.entry_index), 64'(want.entry_index));
      if (got.chunk_offset !== want.chunk_offset)
        report_mismatch("chunk_offset", 64'(got.chunk_offset), 64'(want.chunk_offset));
      if (got.chunk_sectors !== want.chunk_sectors)
        report_mismatch("chunk_sectors", 64'(got.chunk_sectors), 64'(want.chunk_sectors));
      if (got.chunk_time !== want.chunk_time)
        report_mismatch("chunk_time", 64'(got.chunk_time), 64'(want.chunk_time));
      if (got.out_of_range !== want.out_of_range)
        report_mismatch("out_of_range", 64'(got.out_of_range), 64'(want.out_of_range));
      if (got.sector_free !== want.sector_free)
        report_mismatch("sector_free", 64'(got.sector_free), 64'(want.sector_free));
    endtask

    task check_drained();
      if (expected_q.size() != 0)
        report_mismatch("results missing", 64'd0, 64'(expected_q.size()));
    endtask
  endclass

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  rhsm_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  rhsm_pkg::out_t out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [14:0]    cfg_data  = '0;

  sector_map_scoreboard sb = new();

  int unsigned cur_total     = 2;
  int unsigned last_offset   = 2;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  region_header_sector_map_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // The receiver stalls at random, and for one long stretch when hold_left is loaded.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic int unsigned eff_total();
    return (cur_total > MAP_SECTORS) ? MAP_SECTORS : cur_total;
  endfunction

  function automatic rhsm_pkg::in_t make_req(rhsm_pkg::kind_t k, logic [31:0] loc,
                                             logic [31:0] tw, logic [13:0] idx);
    rhsm_pkg::in_t r;
    r.kind = k;
    r.location_word = loc;
    r.time_word = tw;
    r.sector_index = idx;
    return r;
  endfunction

  function automatic rhsm_pkg::in_t make_entry();
    rhsm_pkg::in_t r;
    int unsigned   eff;
    int unsigned   cap;
    int unsigned   cnt;
    int unsigned   off;
    int unsigned   pick;
    eff = eff_total();
    cap = (eff < 255) ? eff : 255;
    r = make_req(rhsm_pkg::KIND_ENTRY, $urandom, $urandom, 14'($urandom_range(16383)));
    pick = $urandom_range(99);
    if (pick < 70) begin
      cnt = $urandom_range(cap);
      off = (pick < 10) ? eff - cnt : $urandom_range(eff - cnt);
      r.location_word = {off[23:0], cnt[7:0]};
      last_offset = off;
    end else if (pick < 85) begin
      cnt = $urandom_range(cap, 1);
      off = eff - cnt + $urandom_range(8, 1);
      r.location_word = {off[23:0], cnt[7:0]};
    end
    return r;
  endfunction

  function automatic rhsm_pkg::in_t make_query();
    rhsm_pkg::in_t r;
    int            near;
    int unsigned   pick;
    r = make_req(rhsm_pkg::KIND_QUERY, $urandom, $urandom, 14'($urandom_range(16383)));
    pick = $urandom_range(99);
    if (pick < 50) begin
      near = int'(last_offset) + int'($urandom_range(300)) - 20;
      if (near < 0) near = 0;
      if (near > 16383) near = 16383;
      r.sector_index = near[13:0];
    end else if (pick < 80) begin
      r.sector_index = 14'($urandom_range(eff_total() - 1));
    end
    return r;
  endfunction

  function automatic rhsm_pkg::in_t make_random(bit allow_begin);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3 && allow_begin)
      return make_req(rhsm_pkg::KIND_BEGIN, $urandom, $urandom, 14'($urandom_range(16383)));
    if (pick < 58) return make_entry();
    if (pick < 95) return make_query();
    return make_req(rhsm_pkg::KIND_NOP, $urandom, $urandom, 14'($urandom_range(16383)));
  endfunction

  task automatic send_request(input rhsm_pkg::in_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_total(input logic [14:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_total(value);
    cur_total = 32'(value);
  endtask

  task automatic set_idle(input int unsigned sender, input int unsigned receiver);
    send_idle_pct = sender;
    recv_idle_pct = receiver;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: reset total first, then a total of 1000.
    set_idle(0, 0);
    send_request(make_req(rhsm_pkg::KIND_QUERY, 32'h0, 32'h0, 14'd0));
    send_request(make_req(rhsm_pkg::KIND_QUERY, 32'h0, 32'h0, 14'd1));
    send_request(make_req(rhsm_pkg::KIND_ENTRY, {24'd0, 8'd2}, 32'h0, 14'd0));
    send_request(make_req(rhsm_pkg::KIND_ENTRY, {24'd1, 8'd2}, 32'hFFFF_FFFF, 14'd0));
    send_request(make_req(rhsm_pkg::KIND_NOP, 32'h0, 32'h0, 14'd0));
    settle();
    write_total(15'd1000);
    send_request(make_req(rhsm_pkg::KIND_BEGIN, 32'h0, 32'h0, 14'd0));
    send_request(make_req(rhsm_pkg::KIND_QUERY, 32'h0, 32'h0, 14'd2));
    send_request(make_req(rhsm_pkg::KIND_ENTRY, {24'd2, 8'd1}, 32'hFFFF_FFFF, 14'h3FFF));
    send_request(make_req(rhsm_pkg::KIND_QUERY, 32'h0, 32'h0, 14'd2));
    send_request(make_req(rhsm_pkg::KIND_ENTRY, {24'd10, 8'd0}, 32'h1234_5678, 14'd0));
    send_request(make_req(rhsm_pkg::KIND_ENTRY, {24'd100, 8'd255}, 32'h0, 14'd0));
    send_request(make_req(rhsm_pkg::KIND_QUERY, 32'h0, 32'h0, 14'd354));
    send_request(make_req(rhsm_pkg::KIND_QUERY, 32'h0, 32'h0, 14'd355));
    send_request(make_req(rhsm_pkg::KIND_ENTRY, {24'd745, 8'd255}, 32'hA5A5_5A5A, 14'd0));
    send_request(make_req(rhsm_pkg::KIND_ENTRY, {24'd746, 8'd255}, 32'h5A5A_A5A5, 14'd0));
    send_request(make_req(rhsm_pkg::KIND_ENTRY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 14'h3FFF));
    send_request(make_req(rhsm_pkg::KIND_QUERY, 32'h0, 32'h0, 14'd999));
    send_request(make_req(rhsm_pkg::KIND_QUERY, 32'h0, 32'h0, 14'd1000));
    send_request(make_req(rhsm_pkg::KIND_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 14'h3FFF));
    send_request(make_req(rhsm_pkg::KIND_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 14'h3FFF));
    send_request(make_req(rhsm_pkg::KIND_BEGIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 14'h3FFF));
    send_request(make_req(rhsm_pkg::KIND_QUERY, 32'h0, 32'h0, 14'd100));

    // Random phases across several totals; the map is not rebuilt when the total changes.
    for (int p = 0; p < 6; p++) begin
      settle();
      write_total(PHASE_TOTALS[p][14:0]);
      case (p % 3)
        0: set_idle(29, 64);
        1: set_idle(64, 29);
        default: set_idle(0, 0);
      endcase
      if (p == 2) hold_left = 400;
      for (int i = 0; i < PHASE_ITEMS; i++) send_request(make_random(1'b1));
    end

    // Entries and queries after one begin at a mid-size total.
    settle();
    write_total(15'd3000);
    set_idle(0, 0);
    send_request(make_req(rhsm_pkg::KIND_BEGIN, $urandom, $urandom,
                          14'($urandom_range(16383))));
    for (int i = 0; i < TAIL_ITEMS; i++) begin
      if (i % 12 == 11) send_request(make_query());
      else send_request(make_entry());
    end

    settle();
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: region_header_sector_map_top.f
+incdir+design
design/rhsm_pkg.sv
design/rhsm_ram.sv
design/rhsm_run_unit.sv
design/region_header_sector_map_top.sv
bench/region_header_sector_map_top_tb.sv
